### rtl/core/pbfa_pkg.sv
// Package for the pixel box filter accumulator.
// Holds shared types, command and status codes and widths; no dependencies.
`default_nettype none
package pbfa_pkg;
  localparam int unsigned ChanW = 20;
  localparam int unsigned AvgW = 16;
  localparam int unsigned CntW = 11;
  localparam int unsigned StatW = 2;
  localparam int unsigned RegW = 9;
  localparam logic [ChanW-1:0] ChanMax = 20'd65280;
  localparam logic [CntW-1:0] MaxSamples = 11'd1024;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [StatW-1:0] ST_OK = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd3;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd_issue;
    logic wr_add;
    logic div_start;
    logic out_load;
  } pbfa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_range;
    logic is_read;
    logic full;
    logic empty;
    logic div_done;
  } pbfa_stat_t;
endpackage
`default_nettype wire

### rtl/core/pbfa_datapath.sv
// Datapath of the pixel box filter accumulator: index math, pixel memories,
// clamp and add, a radix-2 divider per channel and the output register. Uses pbfa_pkg.
`default_nettype none
module pbfa_datapath #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pbfa_pkg::pbfa_cmd_t cmd_c,
  output pbfa_pkg::pbfa_stat_t st,
  input  wire logic cfg_we,
  input  wire logic cfg_idx,
  input  wire logic [pbfa_pkg::RegW-1:0] cfg_data,
  input  wire logic cmd,
  input  wire logic [7:0] pixel_x,
  input  wire logic [7:0] pixel_y,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_red,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_green,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_blue,
  output logic [pbfa_pkg::AvgW-1:0] avg_red,
  output logic [pbfa_pkg::AvgW-1:0] avg_green,
  output logic [pbfa_pkg::AvgW-1:0] avg_blue,
  output logic [pbfa_pkg::CntW-1:0] sample_total,
  output logic [pbfa_pkg::StatW-1:0] status
);
  import pbfa_pkg::*;
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SW = ChanW + CntW - 1 + 6;
  localparam int unsigned DW = $clog2(SW + 1);
  localparam logic [20:0] NumPix = 21'(MAX_PIXELS);

  logic [RegW-1:0] image_width;
  logic [RegW-1:0] image_height;
  logic in_cmd;
  logic [ChanW-1:0] cl_r, cl_g, cl_b;
  logic [17:0] idx_full;
  logic rng_ok;
  logic [AW-1:0] addr;
  logic [AW-1:0] clr_addr;
  logic [SW-1:0] mem_r [MAX_PIXELS];
  logic [SW-1:0] mem_g [MAX_PIXELS];
  logic [SW-1:0] mem_b [MAX_PIXELS];
  logic [CntW-1:0] mem_c [MAX_PIXELS];
  logic [SW-1:0] rd_r, rd_g, rd_b;
  logic [CntW-1:0] rd_c;
  logic [SW-1:0] q_r, q_g, q_b;
  logic [CntW-1:0] rm_r, rm_g, rm_b;
  logic [DW-1:0] div_cnt;
  logic div_busy;
  logic [CntW:0] rm_r_sh, rm_g_sh, rm_b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RegW'(256);
      image_height <= RegW'(256);
    end else if (cfg_we) begin
      if (cfg_idx == REG_WIDTH) image_width <= cfg_data;
      else image_height <= cfg_data;
    end
  end

  function automatic logic [ChanW-1:0] clampc(input logic [ChanW-1:0] v);
    return (v > ChanMax) ? ChanMax : v;
  endfunction

  // Index product is registered before the bounds compare and memory read.
  always_ff @(posedge clk) begin
    if (cmd_c.load) begin
      in_cmd <= cmd;
      cl_r <= clampc(sample_red);
      cl_g <= clampc(sample_green);
      cl_b <= clampc(sample_blue);
      idx_full <= {10'd0, pixel_y} * {9'd0, image_width} + {10'd0, pixel_x};
      rng_ok <= ({1'b0, pixel_x} < image_width) && ({1'b0, pixel_y} < image_height);
    end
  end

  assign addr = AW'(idx_full);

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd_c.clear_step) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd_c.clear_step) begin
      mem_r[clr_addr] <= '0;
      mem_g[clr_addr] <= '0;
      mem_b[clr_addr] <= '0;
      mem_c[clr_addr] <= '0;
    end else if (cmd_c.wr_add) begin
      mem_r[addr] <= rd_r + SW'(cl_r);
      mem_g[addr] <= rd_g + SW'(cl_g);
      mem_b[addr] <= rd_b + SW'(cl_b);
      mem_c[addr] <= rd_c + 1'b1;
    end
    if (cmd_c.rd_issue) begin
      rd_r <= mem_r[addr];
      rd_g <= mem_g[addr];
      rd_b <= mem_b[addr];
      rd_c <= mem_c[addr];
    end
  end

  // Restoring divider, one quotient bit per cycle for all three channels.
  assign rm_r_sh = {rm_r, q_r[SW-1]};
  assign rm_g_sh = {rm_g, q_g[SW-1]};
  assign rm_b_sh = {rm_b, q_b[SW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt <= '0;
    end else if (cmd_c.div_start) begin
      div_busy <= 1'b1;
      div_cnt <= DW'(SW);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == DW'(1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_c.div_start) begin
      q_r <= rd_r;
      q_g <= rd_g;
      q_b <= rd_b;
      rm_r <= '0;
      rm_g <= '0;
      rm_b <= '0;
    end else if (div_busy) begin
      if (rm_r_sh >= {1'b0, rd_c}) begin
        rm_r <= CntW'(rm_r_sh - {1'b0, rd_c});
        q_r <= {q_r[SW-2:0], 1'b1};
      end else begin
        rm_r <= CntW'(rm_r_sh);
        q_r <= {q_r[SW-2:0], 1'b0};
      end
      if (rm_g_sh >= {1'b0, rd_c}) begin
        rm_g <= CntW'(rm_g_sh - {1'b0, rd_c});
        q_g <= {q_g[SW-2:0], 1'b1};
      end else begin
        rm_g <= CntW'(rm_g_sh);
        q_g <= {q_g[SW-2:0], 1'b0};
      end
      if (rm_b_sh >= {1'b0, rd_c}) begin
        rm_b <= CntW'(rm_b_sh - {1'b0, rd_c});
        q_b <= {q_b[SW-2:0], 1'b1};
      end else begin
        rm_b <= CntW'(rm_b_sh);
        q_b <= {q_b[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_c.out_load) begin
      avg_red <= '0;
      avg_green <= '0;
      avg_blue <= '0;
      sample_total <= '0;
      if (!st.in_range) begin
        status <= ST_RANGE;
      end else if (in_cmd == CMD_ADD) begin
        if (st.full) begin
          status <= ST_FULL;
          sample_total <= rd_c;
        end else begin
          status <= ST_OK;
          sample_total <= rd_c + 1'b1;
        end
      end else if (st.empty) begin
        status <= ST_EMPTY;
      end else begin
        status <= ST_OK;
        sample_total <= rd_c;
        avg_red <= AvgW'(q_r);
        avg_green <= AvgW'(q_g);
        avg_blue <= AvgW'(q_b);
      end
    end
  end

  assign st.clear_done = (clr_addr == AW'(MAX_PIXELS - 1));
  assign st.in_range = rng_ok && ({3'b0, idx_full} < NumPix);
  assign st.is_read = (in_cmd == CMD_READ);
  assign st.full = (rd_c >= MaxSamples);
  assign st.empty = (rd_c == '0);
  assign st.div_done = !div_busy;
endmodule
`default_nettype wire

### rtl/core/pbfa_ctrl.sv
// Controller of the pixel box filter accumulator: clear sweep, handshakes
// and sequencing of the datapath. Uses pbfa_pkg.
`default_nettype none
module pbfa_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output pbfa_pkg::pbfa_cmd_t cmd_c,
  input  wire pbfa_pkg::pbfa_stat_t st
);
  import pbfa_pkg::*;
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DIV, S_OUT
  } state_t;
  state_t state;

  always_comb begin
    cmd_c = '0;
    cmd_c.clear_step = (state == S_CLEAR);
    cmd_c.load = (state == S_IDLE) && in_valid && in_ready;
    cmd_c.rd_issue = (state == S_READ);
    cmd_c.wr_add = (state == S_EVAL) && st.in_range && !st.is_read && !st.full;
    cmd_c.div_start = (state == S_EVAL) && st.in_range && st.is_read && !st.empty;
    cmd_c.out_load = ((state == S_EVAL) && !cmd_c.div_start) ||
                     ((state == S_DIV) && st.div_done);
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (st.clear_done) state <= S_IDLE;
        S_IDLE: if (in_valid && in_ready) state <= S_READ;
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (cmd_c.div_start) state <= S_DIV;
          else begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        S_DIV: if (st.div_done) begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/pixel_box_filter_accumulator_top.sv
// Top level of the pixel box filter accumulator.
// Instantiates pbfa_ctrl and pbfa_datapath; uses pbfa_pkg.
`default_nettype none
// One word is in flight at a time, and a word is accepted only while no result
// waits. An add word, an out-of-range word and a read of an empty pixel show
// their result after the index register, the memory read, then the update and
// output load. A read word with samples shows its result once the bit-per-cycle
// divider has run over the 36-bit sums. The next word is accepted at the
// earliest in the cycle after the result is taken. After reset a clearing pass
// over every pixel address runs before the first word.
module pixel_box_filter_accumulator_top #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_idx,
  input  wire logic [pbfa_pkg::RegW-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic cmd,
  input  wire logic [7:0] pixel_x,
  input  wire logic [7:0] pixel_y,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_red,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_green,
  input  wire logic [pbfa_pkg::ChanW-1:0] sample_blue,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [pbfa_pkg::AvgW-1:0] avg_red,
  output logic [pbfa_pkg::AvgW-1:0] avg_green,
  output logic [pbfa_pkg::AvgW-1:0] avg_blue,
  output logic [pbfa_pkg::CntW-1:0] sample_total,
  output logic [pbfa_pkg::StatW-1:0] status
);
  import pbfa_pkg::*;
  pbfa_cmd_t cmd_c;
  pbfa_stat_t st;

  pbfa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd_c, .st
  );

  pbfa_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk, .rst, .cmd_c, .st, .cfg_we, .cfg_idx, .cfg_data, .cmd, .pixel_x,
    .pixel_y, .sample_red, .sample_green, .sample_blue, .avg_red, .avg_green,
    .avg_blue, .sample_total, .status
  );
endmodule
`default_nettype wire

### rtl/core/pbfa_checker.sv
// Port-level checker for the pixel box filter accumulator and its bind.
// Depends on pbfa_pkg and the top level's ports.
`default_nettype none
module pbfa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [pbfa_pkg::AvgW-1:0] avg_red,
  input wire logic [pbfa_pkg::CntW-1:0] sample_total,
  input wire logic [pbfa_pkg::StatW-1:0] status
);
  import pbfa_pkg::*;
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |-> (sample_total == '0 && avg_red == '0))
    else $error("range result not zero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("result dropped");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (sample_total == '0))
    else $error("empty count nonzero");
endmodule

bind pixel_box_filter_accumulator_top pbfa_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .avg_red,
  .sample_total, .status
);
`default_nettype wire

### bench/pixel_box_filter_accumulator_top_tb.sv
// Testbench for pixel_box_filter_accumulator_top: random and directed add and read words
// checked against a behavioral model of the per-pixel running sums. Depends on pbfa_pkg.
`timescale 1ns / 100ps

class pixel_sum_board;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned red_acc[int unsigned];
  int unsigned green_acc[int unsigned];
  int unsigned blue_acc[int unsigned];
  int unsigned hits[int unsigned];
  logic [63:0] pending_words[$];
  int errors;
  int checked;
  int reads_ok;
  int flagged;

  function new();
    width_reg = 256;
    height_reg = 256;
    errors = 0;
    checked = 0;
    reads_ok = 0;
    flagged = 0;
  endfunction

  function void set_reg(logic idx, int unsigned val);
    if (idx == pbfa_pkg::REG_WIDTH) width_reg = val & 'h1FF;
    else height_reg = val & 'h1FF;
  endfunction

  function int unsigned clamp_chan(logic [19:0] v);
    return (v > pbfa_pkg::ChanMax) ? pbfa_pkg::ChanMax : v;
  endfunction

  function void note_word(logic c, logic [7:0] x, logic [7:0] y,
                          logic [19:0] r, logic [19:0] g, logic [19:0] b);
    int unsigned pix;
    int unsigned n;
    logic [15:0] ar, ag, ab;
    logic [10:0] tot;
    logic [1:0] st;
    logic [63:0] word;
    ar = 0; ag = 0; ab = 0; tot = 0;
    pix = y * width_reg + x;
    if (x >= width_reg || y >= height_reg || pix >= 65536) begin
      st = pbfa_pkg::ST_RANGE;
    end else begin
      n = hits.exists(pix) ? hits[pix] : 0;
      if (c == pbfa_pkg::CMD_ADD) begin
        if (n >= 1024) begin
          st = pbfa_pkg::ST_FULL;
          tot = 11'(n);
        end else begin
          if (n == 0) begin
            red_acc[pix] = 0; green_acc[pix] = 0; blue_acc[pix] = 0;
          end
          red_acc[pix] += clamp_chan(r);
          green_acc[pix] += clamp_chan(g);
          blue_acc[pix] += clamp_chan(b);
          hits[pix] = n + 1;
          tot = 11'(n + 1);
          st = pbfa_pkg::ST_OK;
        end
      end else if (n == 0) begin
        st = pbfa_pkg::ST_EMPTY;
      end else begin
        ar = 16'(red_acc[pix] / n);
        ag = 16'(green_acc[pix] / n);
        ab = 16'(blue_acc[pix] / n);
        tot = 11'(n);
        st = pbfa_pkg::ST_OK;
      end
    end
    word = {ar, ag, ab, tot, st, 3'b0};
    pending_words = {pending_words, word};
  endfunction

  function void check_word(logic [15:0] ar, logic [15:0] ag, logic [15:0] ab,
                           logic [10:0] tot, logic [1:0] st);
    logic [63:0] want;
    logic [63:0] got;
    got = {ar, ag, ab, tot, st, 3'b0};
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, actual %h", $time, got);
      return;
    end
    want = pending_words.pop_front();
    checked++;
    if (st == pbfa_pkg::ST_OK && ar + ag + ab != 0) reads_ok++;
    if (st != pbfa_pkg::ST_OK) flagged++;
    if (want[63:48] != ar) begin
      errors++;
      $display("%0t: avg_red expected %0d actual %0d", $time, want[63:48], ar);
    end
    if (want[47:32] != ag) begin
      errors++;
      $display("%0t: avg_green expected %0d actual %0d", $time, want[47:32], ag);
    end
    if (want[31:16] != ab) begin
      errors++;
      $display("%0t: avg_blue expected %0d actual %0d", $time, want[31:16], ab);
    end
    if (want[15:5] != tot) begin
      errors++;
      $display("%0t: sample_total expected %0d actual %0d", $time, want[15:5], tot);
    end
    if (want[4:3] != st) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, want[4:3], st);
    end
  endfunction
endclass

module pixel_box_filter_accumulator_top_tb;
  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_idx;
  logic [8:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [19:0] sample_red;
  logic [19:0] sample_green;
  logic [19:0] sample_blue;
  logic out_valid;
  logic out_ready;
  logic [15:0] avg_red;
  logic [15:0] avg_green;
  logic [15:0] avg_blue;
  logic [10:0] sample_total;
  logic [1:0] status;

  pixel_sum_board board;
  int idle_pct;
  bit hold_off;
  int quiet_cycles;

  pixel_box_filter_accumulator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .sample_red(sample_red), .sample_green(sample_green),
    .sample_blue(sample_blue), .out_valid(out_valid), .out_ready(out_ready),
    .avg_red(avg_red), .avg_green(avg_green), .avg_blue(avg_blue),
    .sample_total(sample_total), .status(status)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    board = new();
    rst = 1; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    in_valid = 0; cmd = 0; pixel_x = 0; pixel_y = 0;
    sample_red = 0; sample_green = 0; sample_blue = 0;
    idle_pct = 12; hold_off = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      board.check_word(avg_red, avg_green, avg_blue, sample_total, status);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("Watchdog expired with %0d words pending", board.pending_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic c, logic [7:0] x, logic [7:0] y,
                           logic [19:0] r, logic [19:0] g, logic [19:0] b);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1; cmd <= c; pixel_x <= x; pixel_y <= y;
    sample_red <= r; sample_green <= g; sample_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(c, x, y, r, g, b);
    in_valid <= 0;
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
  endtask

  function automatic logic [19:0] rand_chan();
    case ($urandom_range(3))
      0: return 20'hFFFFF;
      1: return 20'($urandom_range(65280));
      2: return 20'(20'd65280 + $urandom_range(1));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count, int unsigned xmax, int unsigned ymax);
    logic [7:0] x;
    logic [7:0] y;
    for (int i = 0; i < count; i++) begin
      x = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(xmax));
      y = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(ymax));
      send_word($urandom_range(3) == 0, x, y, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_word(pbfa_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_word(pbfa_pkg::CMD_ADD, 0, 0, 20'hFFFFF, 0, 20'd65280);
    send_word(pbfa_pkg::CMD_ADD, 0, 0, 20'd65281, 20'd1, 20'h0FF00);
    send_word(pbfa_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_word(pbfa_pkg::CMD_ADD, 255, 255, 20'h55555, 20'hAAAAA, 20'd300);
    send_word(pbfa_pkg::CMD_READ, 255, 255, 0, 0, 0);
    send_word(pbfa_pkg::CMD_READ, 17, 200, 0, 0, 0);
    for (int i = 0; i < 1025; i++) begin
      if (i == 300) idle_pct = 0;
      send_word(pbfa_pkg::CMD_ADD, 3, 4, rand_chan(), rand_chan(), rand_chan());
    end
    idle_pct = 12;
    send_word(pbfa_pkg::CMD_READ, 3, 4, 0, 0, 0);
    write_reg(pbfa_pkg::REG_WIDTH, 9'd1);
    write_reg(pbfa_pkg::REG_HEIGHT, 9'd1);
    send_word(pbfa_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_word(pbfa_pkg::CMD_ADD, 1, 0, 0, 0, 0);
    send_word(pbfa_pkg::CMD_ADD, 0, 1, 0, 0, 0);
    random_phase(20, 1, 1);
    write_reg(pbfa_pkg::REG_WIDTH, 9'd0);
    send_word(pbfa_pkg::CMD_ADD, 0, 0, 1, 1, 1);
    write_reg(pbfa_pkg::REG_WIDTH, 9'd300);
    write_reg(pbfa_pkg::REG_HEIGHT, 9'd256);
    send_word(pbfa_pkg::CMD_ADD, 255, 217, 9, 9, 9);
    send_word(pbfa_pkg::CMD_ADD, 255, 218, 9, 9, 9);
    random_phase(60, 255, 255);
    write_reg(pbfa_pkg::REG_WIDTH, 9'd5);
    write_reg(pbfa_pkg::REG_HEIGHT, 9'd3);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(30, 5, 3);
    join
    random_phase(40, 6, 4);
    write_reg(pbfa_pkg::REG_WIDTH, 9'd256);
    write_reg(pbfa_pkg::REG_HEIGHT, 9'd511);
    random_phase(40, 7, 7);
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d words: %0d nonzero averages, %0d flagged as range, full or empty.",
             board.checked, board.reads_ok, board.flagged);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/pbfa_pkg.sv
rtl/core/pbfa_datapath.sv
rtl/core/pbfa_ctrl.sv
rtl/core/pixel_box_filter_accumulator_top.sv
rtl/core/pbfa_checker.sv
bench/pixel_box_filter_accumulator_top_tb.sv
